>>> design/lrcfb_pkg.sv
package lrcfb_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  localparam int unsigned BURST_MAX = 8;
  localparam int unsigned IDX_W     = $clog2(BURST_MAX);

  localparam logic [7:0] CTRL_BYTE = 8'h03;
  localparam logic [7:0] LEN_EXTRA = 8'd8;
  localparam logic [7:0] SOF_RESET = 8'h01;

  // Register word index (paddr[2]).
  localparam logic REG_SOF = 1'b0;

  // Start request: header then trailer when empty.
  localparam logic [IDX_W-1:0] LAST_HDR   = IDX_W'(5);
  localparam logic [IDX_W-1:0] LAST_EMPTY = IDX_W'(7);
  // Data request: byte alone, or byte plus trailer.
  localparam logic [IDX_W-1:0] LAST_DATA  = IDX_W'(0);
  localparam logic [IDX_W-1:0] LAST_CLOSE = IDX_W'(2);

  // Bytes owed to the output for one request.
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [BURST_MAX-1:0]      last;
    logic [BURST_MAX-1:0]      fend;
    logic [IDX_W-1:0]          last_idx;
  } burst_t;

endpackage

>>> design/lrcfb_frame_gen.sv
module lrcfb_frame_gen (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lrcfb_pkg::op_t  op,
  input  logic [7:0]      cmd_first,
  input  logic [7:0]      cmd_second,
  input  logic [7:0]      payload_len,
  input  logic [7:0]      data_byte,
  input  logic [7:0]      sof,
  output logic            burst_valid,
  output lrcfb_pkg::burst_t burst,
  input  logic            burst_take
);
  import lrcfb_pkg::*;

  logic       accept;
  logic       emits;
  logic [7:0] lrc;
  logic [7:0] lrc_next;
  logic [7:0] remaining;
  logic [7:0] remaining_next;
  logic       in_frame;
  logic       in_frame_next;
  logic [7:0] len_byte;
  logic [7:0] hdr_lrc;
  logic [7:0] data_lrc;
  logic [7:0] rem_dec;
  burst_t     burst_next;

  assign in_ready = !burst_valid || burst_take;
  assign accept   = in_valid && in_ready;

  assign len_byte = payload_len + LEN_EXTRA;
  assign hdr_lrc  = sof ^ len_byte ^ CTRL_BYTE ^ cmd_first ^ cmd_second;
  assign data_lrc = lrc ^ data_byte;
  assign rem_dec  = remaining - 8'd1;

  always_comb begin
    burst_next     = '0;
    emits          = 1'b0;
    lrc_next       = lrc;
    remaining_next = remaining;
    in_frame_next  = in_frame;
    unique case (op)
      OP_START: begin
        emits               = 1'b1;
        lrc_next            = hdr_lrc;
        remaining_next      = payload_len;
        in_frame_next       = (payload_len != 8'd0);
        burst_next.bytes[0] = sof;
        burst_next.bytes[1] = len_byte;
        burst_next.bytes[2] = 8'h00;
        burst_next.bytes[3] = CTRL_BYTE;
        burst_next.bytes[4] = cmd_first;
        burst_next.bytes[5] = cmd_second;
        burst_next.bytes[6] = hdr_lrc;
        burst_next.bytes[7] = ~hdr_lrc;
        burst_next.last[5]  = (payload_len != 8'd0);
        burst_next.last[7]  = (payload_len == 8'd0);
        burst_next.fend[7]  = (payload_len == 8'd0);
        burst_next.last_idx = (payload_len == 8'd0) ? LAST_EMPTY : LAST_HDR;
      end
      OP_DATA: begin
        if (in_frame) begin
          emits               = 1'b1;
          lrc_next            = data_lrc;
          remaining_next      = rem_dec;
          in_frame_next       = (rem_dec != 8'd0);
          burst_next.bytes[0] = data_byte;
          burst_next.bytes[1] = data_lrc;
          burst_next.bytes[2] = ~data_lrc;
          burst_next.last[0]  = (rem_dec != 8'd0);
          burst_next.last[2]  = (rem_dec == 8'd0);
          burst_next.fend[2]  = (rem_dec == 8'd0);
          burst_next.last_idx = (rem_dec == 8'd0) ? LAST_CLOSE : LAST_DATA;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lrc         <= '0;
      remaining   <= '0;
      in_frame    <= 1'b0;
      burst_valid <= 1'b0;
    end else begin
      if (accept) begin
        lrc       <= lrc_next;
        remaining <= remaining_next;
        in_frame  <= in_frame_next;
      end
      if (accept && emits) begin
        burst_valid <= 1'b1;
      end else if (burst_take) begin
        burst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emits) begin
      burst <= burst_next;
    end
  end

  a_open_has_count: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> remaining != 8'd0)
    else $error("open frame with no payload left");

  a_empty_closes: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_START && payload_len == 8'd0 |=> !in_frame)
    else $error("empty frame left open");

  a_stray_data: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_DATA && !in_frame && !burst_take |=>
      burst_valid == $past(burst_valid))
    else $error("data outside a frame produced output");

endmodule

>>> design/lrcfb_serializer.sv
module lrcfb_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              burst_valid,
  input  lrcfb_pkg::burst_t burst,
  output logic              burst_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_end
);
  import lrcfb_pkg::*;

  burst_t           cur;
  logic             valid;
  logic [IDX_W-1:0] idx;
  logic             take;
  logic             at_end;
  logic             load;

  assign take       = valid && out_ready;
  assign at_end     = (idx == cur.last_idx);
  assign load       = !valid || (take && at_end);
  assign burst_take = burst_valid && load;

  assign out_valid = valid;
  assign out_byte  = cur.bytes[idx];
  assign out_last  = cur.last[idx];
  assign out_end   = cur.fend[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= burst_valid;
      idx   <= '0;
    end else if (take) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (burst_take) begin
      cur <= burst;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    valid |-> idx <= cur.last_idx)
    else $error("byte index past end of burst");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    valid && out_end |-> out_last && at_end)
    else $error("frame end not on last byte of request");

endmodule

>>> design/lrc_command_frame_builder_core.sv
// Channel  | Dir | Handshake         | Payload
// ---------+-----+-------------------+---------------------------------------------
// s_*      | in  | s_tvalid/s_tready | tuser: operation; tdata: cmd_first,
//          |     |                   |   cmd_second, payload_len, data_byte
// m_*      | out | m_tvalid/m_tready | tdata: out_byte; tlast: last_of_run;
//          |     |                   |   tuser: frame_end
// apb      | in  | psel/penable      | reg 0 @0x0: sof_byte[7:0], reset 0x01
//
// A request is registered as a burst of 1..8 bytes in the cycle it is taken;
// the output serializer then sends one byte per cycle while m_tready is high.
// A start request yields 6 or 8 output bytes, a data request 1 or 3; the rate
// is set by the serializer, which sends one byte a cycle while m_tready is high.
// One burst waits behind the one being sent, so s_tready stays high until both
// are occupied. Stray data requests are accepted and send nothing.
// rst is synchronous and clears frame state, LRC and both burst slots.
module lrc_command_frame_builder_core (
  input  logic        clk,
  input  logic        rst,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [7:0] cmd_first, [15:8] cmd_second,
                                 // [23:16] payload_len, [31:24] data_byte
  input  logic        s_tuser,   // [0] operation: 0 start, 1 data
  // byte stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser    // [0] frame_end
);
  import lrcfb_pkg::*;

  logic   sof_wr;
  logic [7:0] sof;
  logic   burst_valid;
  logic   burst_take;
  burst_t burst;
  op_t    op;

  // Config: one word, byte offset ignored.
  assign pready = 1'b1;
  assign sof_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SOF);
  assign prdata = (paddr[2] == REG_SOF) ? {24'd0, sof} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sof <= SOF_RESET;
    end else if (sof_wr) begin
      sof <= pwdata[7:0];
    end
  end

  assign op = op_t'(s_tuser);

  lrcfb_frame_gen u_gen (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .op          (op),
    .cmd_first   (s_tdata[7:0]),
    .cmd_second  (s_tdata[15:8]),
    .payload_len (s_tdata[23:16]),
    .data_byte   (s_tdata[31:24]),
    .sof         (sof),
    .burst_valid (burst_valid),
    .burst       (burst),
    .burst_take  (burst_take)
  );

  lrcfb_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .burst_valid (burst_valid),
    .burst       (burst),
    .burst_take  (burst_take),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .out_last    (m_tlast),
    .out_end     (m_tuser)
  );

  a_sof_write: assert property (@(posedge clk) disable iff (rst)
    sof_wr |=> sof == $past(pwdata[7:0]))
    else $error("sof register write lost");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !burst_valid |-> s_tready)
    else $error("request stalled with free slot");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    burst_valid && !burst_take |=> burst_valid)
    else $error("pending burst dropped");

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lrcfb_pkg::*;

  // APB byte addresses: register i at 4*i, word index in paddr[2].
  localparam logic [2:0] ADDR_SOF   = {REG_SOF, 2'b00};
  localparam logic [2:0] ADDR_SPARE = {~REG_SOF, 2'b00};   // no register here

  // Cycles allowed after the last byte before the block counts as quiet.
  localparam int unsigned QUIET_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned REPORT_MAX   = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [7:0] cmd_first, [15:8] cmd_second,
                                // [23:16] payload_len, [31:24] data_byte
  logic        s_tuser = 1'b0;  // [0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [7:0] out_byte
  logic        m_tlast;
  logic        m_tuser;         // [0] frame_end

  lrc_command_frame_builder_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor: own copy of the SOF register and frame state. Every
  // accepted request appends the bytes it must produce to frame_bytes_due.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] val;
    logic       last;
    logic       fend;
  } frame_byte_t;

  frame_byte_t frame_bytes_due[$];

  logic [7:0] sof_now    = SOF_RESET;
  logic [7:0] lrc_run    = '0;
  logic [7:0] pay_left   = '0;
  logic       frame_open = 1'b0;

  function automatic void due_byte(logic [7:0] val, logic last, logic fend);
    frame_byte_t b;
    b.val  = val;
    b.last = last;
    b.fend = fend;
    frame_bytes_due.push_back(b);
  endfunction

  // LRC, then its complement which closes the frame and the request.
  function automatic void due_trailer();
    due_byte(lrc_run, 1'b0, 1'b0);
    due_byte(8'hFF - lrc_run, 1'b1, 1'b1);
    frame_open = 1'b0;
    pay_left   = '0;
  endfunction

  function automatic void predict_frame_bytes(op_t op, logic [7:0] c1, logic [7:0] c2,
                                              logic [7:0] len, logic [7:0] d);
    logic [7:0] len_byte;
    if (op == OP_START) begin
      // Length byte wraps modulo 256; any open frame is simply dropped.
      len_byte   = len + LEN_EXTRA;
      lrc_run    = sof_now ^ len_byte ^ CTRL_BYTE ^ c1 ^ c2;
      pay_left   = len;
      frame_open = 1'b1;
      due_byte(sof_now, 1'b0, 1'b0);
      due_byte(len_byte, 1'b0, 1'b0);
      due_byte(8'h00, 1'b0, 1'b0);
      due_byte(CTRL_BYTE, 1'b0, 1'b0);
      due_byte(c1, 1'b0, 1'b0);
      due_byte(c2, len != 8'd0, 1'b0);
      if (len == 8'd0) due_trailer();
    end else if (frame_open) begin
      lrc_run  = lrc_run ^ d;
      pay_left = pay_left - 8'd1;
      due_byte(d, pay_left != 8'd0, 1'b0);
      if (pay_left == 8'd0) due_trailer();
    end
    // data outside a frame: dropped, nothing due
  endfunction

  // ---------------------------------------------------------------------------
  // Byte checker: each byte taken on the output is matched with the oldest one
  // due. Mismatches past the first few are only counted.
  // ---------------------------------------------------------------------------
  int unsigned err_count = 0;
  frame_byte_t got_due;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (frame_bytes_due.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX)
          $display("%0t: unexpected byte %02h last %0b end %0b", $realtime,
                   m_tdata, m_tlast, m_tuser);
      end else begin
        got_due = frame_bytes_due.pop_front();
        if (m_tdata !== got_due.val || m_tlast !== got_due.last ||
            m_tuser !== got_due.fend) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("%0t: byte mismatch exp %02h/%0b/%0b got %02h/%0b/%0b",
                     $realtime, got_due.val, got_due.last, got_due.fend,
                     m_tdata, m_tlast, m_tuser);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls at stall_pct, plus a long hold-off counted
  // here once hold_req is posted.
  // ---------------------------------------------------------------------------
  int unsigned stall_pct = 0;
  int unsigned idle_pct  = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_left = 0;

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver. Entered and left at a falling edge; s_tvalid stays high
  // between back-to-back requests.
  // ---------------------------------------------------------------------------
  task automatic send_req(op_t op, logic [7:0] c1, logic [7:0] c2,
                          logic [7:0] len, logic [7:0] d);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {d, len, c2, c1};
    do @(posedge clk); while (!s_tready);
    predict_frame_bytes(op, c1, c2, len, d);
    @(negedge clk);
  endtask

  task automatic send_start(logic [7:0] c1, logic [7:0] c2, logic [7:0] len);
    send_req(OP_START, c1, c2, len, 8'($urandom_range(255)));
  endtask

  task automatic send_data(logic [7:0] d);
    send_req(OP_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
             8'($urandom_range(255)), d);
  endtask

  // Stop offering, let every due byte come out, then give a stray data
  // request time to clear before anything else happens.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (frame_bytes_due.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; written at the edge closing the access.
  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready && addr[2] == REG_SOF) sof_now = value[7:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, stray data, empty payload, length wrap, restart mid-frame.
  task automatic test_directed_frames();
    send_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00);     // stray, nothing out
    send_req(OP_DATA, 8'hFF, 8'hFF, 8'hFF, 8'hFF);     // stray, all ones
    send_req(OP_START, 8'h00, 8'hFF, 8'd0, 8'hFF);     // empty payload
    send_req(OP_START, 8'hFF, 8'h00, 8'd1, 8'h00);
    send_data(8'hFF);
    send_start(8'hA5, 8'h5A, 8'd2);
    send_data(8'h00);
    send_data(8'h3C);
    send_data(8'h77);                                  // after close: dropped
    send_start(8'h12, 8'h34, 8'd255);                  // length byte wraps to 7
    send_data(8'h80);
    send_data(8'h01);
    send_start(8'hC3, 8'h3C, 8'd248);                  // restart, length byte 0
    send_data(8'h55);
    send_start(8'h0F, 8'hF0, 8'd247);                  // length byte 0xFF
    send_data(8'hAA);
    send_start(8'h69, 8'h96, 8'd3);                    // abandons the 247 frame
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h5A);                                  // stray again
    wait_drained();
  endtask

  // SOF extremes, a write to an empty address, and a write with a frame open.
  task automatic test_sof_register();
    apb_write(ADDR_SOF, 32'h0000_0000);
    send_start(8'h81, 8'h18, 8'd1);
    send_data(8'hE7);
    wait_drained();
    apb_write(ADDR_SOF, 32'hFFFF_FFFF);
    send_start(8'h42, 8'h24, 8'd0);
    wait_drained();
    apb_write(ADDR_SPARE, 32'h0000_005C);              // must not change SOF
    send_start(8'h99, 8'h66, 8'd0);
    wait_drained();
    // Frame opened under 0xFF keeps that SOF in its LRC after the write.
    send_start(8'h3A, 8'hA3, 8'd2);
    send_data(8'h11);
    wait_drained();
    apb_write(ADDR_SOF, 32'h0000_0080);
    send_data(8'h22);
    send_start(8'h01, 8'h02, 8'd0);                    // new frame under 0x80
    wait_drained();
  endtask

  // Mostly whole frames with random content; some abandoned frames (any
  // length, including the wrapping ones) and stray data in between.
  task automatic run_random_items(int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned n_data;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8 && !frame_open) begin
        send_data(8'($urandom_range(255)));
      end else if (pick < 20) begin
        len    = $urandom_range(255, 1);
        n_data = $urandom_range((len < 7) ? len - 1 : 6, 0);
        send_start(8'($urandom_range(255)), 8'($urandom_range(255)), 8'(len));
        repeat (n_data) send_data(8'($urandom_range(255)));
        sent += 1 + n_data;
      end else begin
        pick = $urandom_range(99);
        if (pick < 70)      len = $urandom_range(6, 0);
        else if (pick < 92) len = $urandom_range(16, 7);
        else                len = $urandom_range(40, 17);
        send_start(8'($urandom_range(255)), 8'($urandom_range(255)), 8'(len));
        repeat (len) send_data(8'($urandom_range(255)));
        sent += 1 + len;
      end
    end
    wait_drained();
  endtask

  // Idle and stall phases, each under its own SOF value.
  task automatic test_random_traffic();
    apb_write(ADDR_SOF, 32'h0000_0000);
    idle_pct  = 0;
    stall_pct = 0;
    run_random_items(90);
    apb_write(ADDR_SOF, 32'h0000_00FF);
    idle_pct  = 50;
    stall_pct = 0;
    run_random_items(90);
    apb_write(ADDR_SOF, $urandom_range(255));
    idle_pct  = 0;
    stall_pct = 50;
    run_random_items(90);
    apb_write(ADDR_SOF, 32'(SOF_RESET));
    idle_pct  = 13;
    stall_pct = 13;
    run_random_items(90);
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // Output held off for a long stretch while requests keep coming, so both
  // burst slots fill and s_tready drops; then the sender waits for the drain.
  task automatic test_backpressure();
    int unsigned k;
    @(posedge clk);
    hold_req = HOLD_CYCLES;
    @(negedge clk);
    for (k = 0; k < 6; k++) begin
      send_start(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd3);
      repeat (3) send_data(8'($urandom_range(255)));
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_frames();
    test_sof_register();
    test_backpressure();
    test_random_traffic();

    if (err_count == 0 && frame_bytes_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
